// ===== rtl/core/sha_pkg.sv =====
// Package for the SHA-256 digest block: types, round constants, round functions.
// No dependencies.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam int QueueDepth = 2;

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror(input logic [31:0] x, input int amt);
      return (x >> amt) | (x << (32 - amt));
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
   endfunction

endpackage

// ===== rtl/core/sha_stream_if.sv =====
// Valid/ready channel interface carrying one item of payload type.
// The payload type is a parameter; no package dependencies.
interface sha_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sha_queue.sv =====
// Short item queue between the front end and the compression engine.
// Depends on sha_pkg.
module sha_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sha_pkg::req_type push_item,
   output logic             full,
   input  logic             pop,
   output sha_pkg::req_type pop_item,
   output logic             empty
);
   sha_pkg::req_type slot_ff [sha_pkg::QueueDepth];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'(sha_pkg::QueueDepth));
endmodule

// ===== rtl/core/sha_front.sv =====
// Front end: accepts items, drops idle ones, pushes the rest into the queue.
// Depends on sha_pkg, sha_stream_if.
module sha_front (
   sha_stream_if.sink       req,
   input  logic             full,
   output logic             push,
   output sha_pkg::req_type push_item
);
   // drop items with neither a byte nor an end mark
   assign req.ready = !full;
   assign push_item = req.payload;
   assign push      = req.valid && !full &&
                      (req.payload.byte_valid || req.payload.end_of_message);
endmodule

// ===== rtl/core/sha_engine.sv =====
// Compression engine: packs bytes, runs 64 rounds per block, pads, emits digest.
// Depends on sha_pkg, sha_stream_if.
module sha_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  sha_pkg::req_type pop_item,
   output logic             pop,
   sha_stream_if.source     rsp
);
   sha_pkg::state_type state_ff, state_in;
   logic [31:0] hash_ff [8];
   logic [31:0] var_ff  [8];
   logic [31:0] win_ff  [16];
   logic [63:0] bits_ff;
   logic [5:0]  bidx_ff;
   logic [5:0]  ridx_ff;
   logic [2:0]  widx_ff;
   logic        ending_ff;   // padding phase of a message
   logic        tail_ff;     // the block being filled carries the length
   logic [63:0] len_ff;

   logic        put;         // a byte goes into the window this cycle
   logic [7:0]  put_byte;
   logic [31:0] w, t1, t2;
   logic [3:0]  r15, r2, r9, r0;

   // schedule word and round sums
   always_comb begin
      r0  = ridx_ff[3:0];
      r15 = r0 + 4'd1;
      r2  = r0 + 4'd14;
      r9  = r0 + 4'd9;
      if (ridx_ff < 6'd16) begin
         w = win_ff[r0];
      end else begin
         w = win_ff[r0] + sha_pkg::sig0(win_ff[r15]) + win_ff[r9] +
             sha_pkg::sig1(win_ff[r2]);
      end
      t1 = var_ff[7] + sha_pkg::bsig1(var_ff[4]) +
           ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6])) +
           sha_pkg::RoundConst[ridx_ff] + w;
      t2 = sha_pkg::bsig0(var_ff[0]) +
           ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^
            (var_ff[1] & var_ff[2]));
   end

   // choose the byte for this cycle: message byte or padding
   always_comb begin
      put      = 1'b0;
      put_byte = 8'd0;
      pop      = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               if (pop_item.byte_valid) begin
                  put      = 1'b1;
                  put_byte = pop_item.data_byte;
               end
               if (put && bidx_ff == 6'd63) begin
                  state_in = sha_pkg::ST_ROUND;
               end else if (pop_item.end_of_message) begin
                  state_in = sha_pkg::ST_PAD;
               end
            end
         end
         sha_pkg::ST_PAD: begin
            put = 1'b1;
            if (len_ff[0]) begin
               put_byte = sha_pkg::PadByte;
            end else if (tail_ff && bidx_ff >= sha_pkg::LenPos) begin
               put_byte = len_ff[8 * (7 - bidx_ff[2:0]) +: 8];
            end
            if (bidx_ff == 6'd63) begin
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (ridx_ff == 6'd63) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            if (!ending_ff) begin
               state_in = sha_pkg::ST_IDLE;
            end else if (tail_ff) begin
               state_in = sha_pkg::ST_EMIT;
            end else begin
               state_in = sha_pkg::ST_PAD;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (rsp.ready && widx_ff == 3'd7) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff   <= sha_pkg::InitHash;
         bits_ff   <= 64'd0;
         bidx_ff   <= 6'd0;
         ridx_ff   <= 6'd0;
         widx_ff   <= 3'd0;
         ending_ff <= 1'b0;
         tail_ff   <= 1'b0;
         len_ff    <= 64'd0;
      end else begin
         if (put) begin
            if (bidx_ff[1:0] == 2'd0) begin
               win_ff[bidx_ff[5:2]] <= {put_byte, 24'd0};
            end else begin
               win_ff[bidx_ff[5:2]][8 * (3 - bidx_ff[1:0]) +: 8] <= put_byte;
            end
            bidx_ff <= bidx_ff + 6'd1;
         end
         if (state_ff == sha_pkg::ST_IDLE && pop) begin
            if (pop_item.byte_valid) begin
               bits_ff <= bits_ff + 64'd8;
            end
            if (pop_item.end_of_message) begin
               // hold the length; bit 0 marks the padding byte still owed
               len_ff    <= bits_ff + (pop_item.byte_valid ? 64'd8 : 64'd0) + 64'd1;
               ending_ff <= 1'b1;
               tail_ff   <= 1'b0;
            end
         end
         // place the padding byte; the length fits behind it below position 56
         if (state_ff == sha_pkg::ST_PAD) begin
            if (len_ff[0]) begin
               len_ff[0] <= 1'b0;
               if (bidx_ff < sha_pkg::LenPos) begin
                  tail_ff <= 1'b1;
               end
            end
            if (bidx_ff == 6'd63) begin
               var_ff <= hash_ff;
            end
         end
         if (state_ff == sha_pkg::ST_IDLE && put && bidx_ff == 6'd63) begin
            var_ff <= hash_ff;
         end
         if (state_ff == sha_pkg::ST_ROUND) begin
            if (ridx_ff >= 6'd16) begin
               win_ff[r0] <= w;
            end
            var_ff[7] <= var_ff[6];
            var_ff[6] <= var_ff[5];
            var_ff[5] <= var_ff[4];
            var_ff[4] <= var_ff[3] + t1;
            var_ff[3] <= var_ff[2];
            var_ff[2] <= var_ff[1];
            var_ff[1] <= var_ff[0];
            var_ff[0] <= t1 + t2;
            ridx_ff   <= ridx_ff + 6'd1;
         end
         // fold the block in; a padding block without the length owes one more
         if (state_ff == sha_pkg::ST_FOLD) begin
            for (int j = 0; j < 8; j++) begin
               hash_ff[j] <= hash_ff[j] + var_ff[j];
            end
            if (ending_ff && !tail_ff) begin
               tail_ff <= 1'b1;
            end
         end
         if (state_ff == sha_pkg::ST_EMIT && rsp.ready) begin
            widx_ff <= widx_ff + 3'd1;
            if (widx_ff == 3'd7) begin
               hash_ff   <= sha_pkg::InitHash;
               bits_ff   <= 64'd0;
               ending_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp.valid               = (state_ff == sha_pkg::ST_EMIT);
   assign rsp.payload.digest_word = hash_ff[widx_ff];
   assign rsp.payload.word_index  = widx_ff;
   assign rsp.payload.last_word   = (widx_ff == 3'd7);
endmodule

// ===== rtl/core/sha256_message_digest.sv =====
// SHA-256 digest of a byte stream; top level joining front end, queue and engine.
// Depends on sha_pkg, sha_stream_if, sha_front, sha_queue, sha_engine.
// A byte is packed into the window; a block-filling byte starts 64 rounds
// on the shared round unit and one fold; an end item adds the padding bytes,
// one per cycle, one or two padded blocks, then the 8 digest words.
// Bytes wait in the queue while the engine runs rounds, pads or emits words.
// Reset: synchronous; hash words return to the initial values, counts to zero.
module sha256_message_digest (
   input logic clock,
   input logic reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   logic             push, pop, full, empty;
   sha_pkg::req_type push_item, pop_item;

   sha_front u_front (
      .req       (req),
      .full      (full),
      .push      (push),
      .push_item (push_item)
   );

   sha_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   sha_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp      (rsp)
   );
endmodule
